FILE: hdl/olt_pkg.sv
// Shared types, codes and sizing constants for the ordered list table.
// Used by olt_ctrl and ordered_list_table; no dependencies.
package olt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = CNT_W + 1;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_DELETE     = 3'd2,
    ACT_FIND       = 3'd3,
    ACT_DUMP       = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    KIND_FOUND     = 3'd0,
    KIND_NOT_FOUND = 3'd1,
    KIND_ELEMENT   = 3'd2,
    KIND_EMPTY     = 3'd3,
    KIND_FULL      = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DUMP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

  // The list is kept as a ring: logical index off lives at (head + off) mod CAPACITY.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hdl/olt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module olt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/olt_ctrl.sv
// Sequencer for the ordered list table: ring pointers, table walks and the result register.
// Depends on olt_pkg; drives the table RAM through a ram_req_t bundle.
module olt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               action_i,
  input  logic [olt_pkg::VAL_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               kind_o,
  output logic [olt_pkg::POS_W-1:0] position_o,
  output logic [olt_pkg::VAL_W-1:0] item_value_o,
  output logic                     last_o,
  output olt_pkg::ram_req_t        ram_req_o,
  input  logic [olt_pkg::VAL_W-1:0] rd_data_i
);
  import olt_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] walk_q, walk_d;
  logic [CNT_W-1:0] wr_ptr_q, wr_ptr_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_pos_q, pend_pos_d;
  action_e          action_q, action_d;
  logic [VAL_W-1:0] value_q, value_d;
  kind_e            resp_kind_q, resp_kind_d;
  logic [IDX_W-1:0] resp_pos_q, resp_pos_d;

  logic             out_vld_q, out_vld_d;
  kind_e            out_kind_q, out_kind_d;
  logic [IDX_W-1:0] out_pos_q, out_pos_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic             out_last_q, out_last_d;

  action_e          in_act;
  logic             in_fire, out_free, walk_more, hit, full, rd_issue, walk_done;
  logic [IDX_W-1:0] head_dec;

  assign in_act    = action_e'(action_i);
  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_vld_q || out_ready_i;
  assign walk_more = walk_q < count_q;
  assign walk_done = !pend_q && !walk_more;
  assign hit       = pend_q && (rd_data_i == value_q);
  assign full      = count_q == CNT_W'(CAPACITY);
  assign head_dec  = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);

  // A dump only reads ahead when the RAM read register will be free next cycle.
  always_comb begin
    case (state_q)
      ST_SCAN, ST_SHIFT: rd_issue = walk_more;
      ST_DUMP:           rd_issue = walk_more && (!pend_q || out_free);
      default:           rd_issue = 1'b0;
    endcase
  end

  // Next state and datapath registers.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    walk_d      = rd_issue ? walk_q + CNT_W'(1) : walk_q;
    wr_ptr_d    = wr_ptr_q;
    pend_d      = rd_issue;
    pend_pos_d  = rd_issue ? walk_q[IDX_W-1:0] : pend_pos_q;
    action_d    = action_q;
    value_d     = value_q;
    resp_kind_d = resp_kind_q;
    resp_pos_d  = resp_pos_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_pos_d   = out_pos_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          action_d   = in_act;
          value_d    = value_i;
          walk_d     = '0;
          resp_pos_d = '0;
          case (in_act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (full) begin
                resp_kind_d = KIND_FULL;
                state_d     = ST_RESP;
              end else begin
                count_d = count_q + CNT_W'(1);
                if (in_act == ACT_PUSH_FRONT) begin
                  head_d = head_dec;
                end
              end
            end
            ACT_DELETE, ACT_FIND: begin
              state_d = ST_SCAN;
            end
            ACT_DUMP: begin
              if (count_q == '0) begin
                resp_kind_d = KIND_EMPTY;
                state_d     = ST_RESP;
              end else begin
                state_d = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (action_q == ACT_FIND) begin
            resp_kind_d = KIND_FOUND;
            resp_pos_d  = pend_pos_q;
            pend_d      = 1'b0;
            state_d     = ST_RESP;
          end else begin
            // The read of the following entry is already in flight.
            wr_ptr_d = CNT_W'(pend_pos_q);
            state_d  = ST_SHIFT;
          end
        end else if (walk_done) begin
          if (action_q == ACT_FIND) begin
            resp_kind_d = KIND_NOT_FOUND;
            state_d     = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        if (pend_q) begin
          wr_ptr_d = wr_ptr_q + CNT_W'(1);
        end else if (!walk_more) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (pend_q && out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = KIND_ELEMENT;
          out_pos_d  = pend_pos_q;
          out_val_d  = rd_data_i;
          out_last_d = CNT_W'(pend_pos_q) == count_q - CNT_W'(1);
        end
        if (pend_q && !out_free) begin
          pend_d = 1'b1;
        end
        if (walk_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = resp_kind_q;
          out_pos_d  = resp_pos_q;
          out_val_d  = '0;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and RAM requests.
  always_comb begin
    in_ready_o        = state_q == ST_IDLE;
    ram_req_o.rd_en   = rd_issue;
    ram_req_o.rd_addr = phys_idx(head_q, walk_q);
    ram_req_o.wr_en   = 1'b0;
    ram_req_o.wr_addr = phys_idx(head_q, count_q);
    ram_req_o.wr_data = value_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !full &&
            (in_act == ACT_PUSH_FRONT || in_act == ACT_PUSH_BACK)) begin
          ram_req_o.wr_en = 1'b1;
          if (in_act == ACT_PUSH_FRONT) begin
            ram_req_o.wr_addr = head_dec;
          end
        end
      end
      ST_SHIFT: begin
        ram_req_o.wr_en   = pend_q;
        ram_req_o.wr_addr = phys_idx(head_q, wr_ptr_q);
        ram_req_o.wr_data = rd_data_i;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign kind_o       = out_kind_q;
  assign position_o   = POS_W'(out_pos_q);
  assign item_value_o = out_val_q;
  assign last_o       = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      head_q    <= '0;
      walk_q    <= '0;
      wr_ptr_q  <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      head_q    <= head_d;
      walk_q    <= walk_d;
      wr_ptr_q  <= wr_ptr_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pos_q  <= pend_pos_d;
    action_q    <= action_d;
    value_q     <= value_d;
    resp_kind_q <= resp_kind_d;
    resp_pos_q  <= resp_pos_d;
    out_kind_q  <= out_kind_d;
    out_pos_q   <= out_pos_d;
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q)
    else $error("read data left pending on return to idle");

  a_rw_distinct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.wr_en && ram_req_o.rd_en |-> ram_req_o.wr_addr != ram_req_o.rd_addr)
    else $error("table read and write hit the same entry");

  a_shift_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT |-> wr_ptr_q < walk_q)
    else $error("compaction write overtook the read pointer");

endmodule

FILE: hdl/ordered_list_table.sv
// Ordered list table: a bounded list of signed values kept as a ring in one RAM.
// A push writes the table as it is accepted; a full push gives a full result instead.
// Find and delete walk the table from the head, one table read per cycle.
// Dump gives one element per cycle while the output is taken, or list empty.
// One transfer is worked on at a time; the table RAM read port sets the pace.
// Reset clears the count, ring head and control state; table contents are not cleared.
module ordered_list_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                action_i,
  input  logic signed [olt_pkg::VAL_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                kind_o,
  output logic [olt_pkg::POS_W-1:0] position_o,
  output logic signed [olt_pkg::VAL_W-1:0] item_value_o,
  output logic                      last_o
);
  import olt_pkg::*;

  ram_req_t         ram_req;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] item_value;

  olt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .position_o   (position_o),
    .item_value_o (item_value),
    .last_o       (last_o),
    .ram_req_o    (ram_req),
    .rd_data_i    (rd_data)
  );

  olt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (rd_data)
  );

  assign item_value_o = item_value;

endmodule
